>>> hw/rtl/lbs8_pkg.sv
// ----------------------------------------------------------------------------
// lbs8_pkg
// Shared types, sizes and helpers for the largest 8-connected blob sizer.
// ----------------------------------------------------------------------------
package lbs8_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int CELL_TOTAL = MAX_ROWS * MAX_COLS;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
    localparam int CNT_W  = ADDR_W + 1;
    localparam int NR_W   = ROW_W + 2;
    localparam int NC_W   = COL_W + 2;

    localparam int CFG_W  = 7;
    localparam int SIZE_W = 13;
    localparam int IDX_W  = 1;

    localparam logic [IDX_W-1:0] REG_ROW_COUNT = 1'd0;
    localparam logic [IDX_W-1:0] REG_COL_COUNT = 1'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_POP,
        ST_POP_WAIT,
        ST_NB_CALC,
        ST_NB_READ,
        ST_NB_CHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
    } pos_t;

    typedef struct packed {
        logic signed [1:0] dr;
        logic signed [1:0] dc;
    } offset_t;

    // The eight neighbors around a cell, center left out.
    function automatic offset_t nb_offset(input logic [2:0] k);
        offset_t o;
        case (k)
            3'd0:    o = '{dr: -2'sd1, dc: -2'sd1};
            3'd1:    o = '{dr: -2'sd1, dc:  2'sd0};
            3'd2:    o = '{dr: -2'sd1, dc:  2'sd1};
            3'd3:    o = '{dr:  2'sd0, dc: -2'sd1};
            3'd4:    o = '{dr:  2'sd0, dc:  2'sd1};
            3'd5:    o = '{dr:  2'sd1, dc: -2'sd1};
            3'd6:    o = '{dr:  2'sd1, dc:  2'sd0};
            3'd7:    o = '{dr:  2'sd1, dc:  2'sd1};
            default: o = '{dr:  2'sd0, dc:  2'sd0};
        endcase
        return o;
    endfunction

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] top);
        logic [CFG_W-1:0] r;
        if (v == '0)
            r = CFG_W'(1);
        else if (v > top)
            r = top;
        else
            r = v;
        return r;
    endfunction

endpackage

>>> hw/rtl/largest_blob_size_8conn.sv
// ----------------------------------------------------------------------------
// largest_blob_size_8conn
// Size of the largest 8-connected group of set cells in a binary image.
// ----------------------------------------------------------------------------
// Usage: cells arrive one word per accepted start (start high, busy low), in
// row-major order, with frame_end on the last cell. Image size comes from the
// row_count and col_count registers, written through cfg_we/cfg_index/cfg_data
// while the block is idle. Cells beyond rows*cols are dropped.
// Busy stays low while cells load. On frame_end, busy rises and a flood
// search runs out of two single-port-read memories: a cell map (occupied
// and seen bits, seen cleared as each cell loads) and a stack. The search
// reads each scanned cell from the map, pops each set cell from the stack
// and checks each of its 8 neighbors, reading the map only when the
// neighbor is inside the loaded image.
// The result is on largest_size while done is high for one cycle, then
// busy drops. The receiver cannot stall; the word must be taken that cycle.
// Reset returns the sizes to 64x64 and the block to idle; no memory clear
// pass is needed.
// ----------------------------------------------------------------------------
module largest_blob_size_8conn
    import lbs8_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              cell_set,
    input  logic              frame_end,
    output logic              done,
    output logic [SIZE_W-1:0] largest_size,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    // Map entry: bit 1 is seen, bit 0 is occupied.
    logic [1:0]  map_mem [CELL_TOTAL];
    pos_t        stk_mem [CELL_TOTAL];

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   rows_reg, cols_reg;
    logic [CNT_W-1:0]   load_pos_reg, load_pos_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic [ROW_W-1:0]   scan_r_reg, scan_r_next;
    logic [COL_W-1:0]   scan_c_reg, scan_c_next;
    logic [CNT_W-1:0]   top_reg, top_next;
    logic [SIZE_W-1:0]  group_reg, group_next;
    logic [SIZE_W-1:0]  best_reg, best_next;
    pos_t               here_reg, here_next;
    logic [2:0]         k_reg, k_next;
    logic [CNT_W-1:0]   q_reg, q_next;
    logic               nb_ok_reg, nb_ok_next;
    pos_t               nb_reg, nb_next;

    logic [1:0]         map_rd_reg;
    pos_t               stk_rd_reg;

    logic               map_we, map_re, stk_we, stk_re;
    logic [ADDR_W-1:0]  map_wa, map_ra, stk_wa, stk_ra;
    logic [1:0]         map_wd;
    pos_t               stk_wd;

    logic [CNT_W-1:0]   area;
    logic               accept;
    logic               scan_hit, nb_hit, nb_live, last_nb;
    offset_t            off;
    logic signed [NR_W-1:0] nr;
    logic signed [NC_W-1:0] nc;

    assign area    = CNT_W'(CNT_W'(rows_reg) * CNT_W'(cols_reg));
    assign accept  = start && (state_reg == ST_IDLE);
    assign scan_hit = (scan_reg < load_pos_reg) && map_rd_reg[0] && !map_rd_reg[1];
    assign nb_hit  = map_rd_reg[0] && !map_rd_reg[1];
    assign nb_live = nb_ok_reg && (q_reg < load_pos_reg);
    assign last_nb = (k_reg == 3'd7);

    assign off = nb_offset(k_reg);
    assign nr  = $signed({2'b00, here_reg.r}) + NR_W'(off.dr);
    assign nc  = $signed({2'b00, here_reg.c}) + NC_W'(off.dc);

    // Configuration registers hold the clamped sizes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= CFG_W'(MAX_ROWS);
            cols_reg <= CFG_W'(MAX_COLS);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_COUNT: rows_reg <= clamp_size(cfg_data, CFG_W'(MAX_ROWS));
                REG_COL_COUNT: cols_reg <= clamp_size(cfg_data, CFG_W'(MAX_COLS));
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start && frame_end)
                    state_next = ST_SCAN_RD;
            ST_SCAN_RD:
                state_next = (scan_reg >= area) ? ST_DONE : ST_SCAN_CHK;
            ST_SCAN_CHK:
                state_next = scan_hit ? ST_POP : ST_SCAN_RD;
            ST_POP:
                state_next = (top_reg == '0) ? ST_SCAN_RD : ST_POP_WAIT;
            ST_POP_WAIT:
                state_next = ST_NB_CALC;
            ST_NB_CALC:
                state_next = ST_NB_READ;
            ST_NB_READ:
                if (nb_live)
                    state_next = ST_NB_CHK;
                else
                    state_next = last_nb ? ST_POP : ST_NB_CALC;
            ST_NB_CHK:
                state_next = last_nb ? ST_POP : ST_NB_CALC;
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs and memory controls.
    always_comb
    begin
        busy   = (state_reg != ST_IDLE);
        done   = (state_reg == ST_DONE);
        map_we = 1'b0;
        map_wa = load_pos_reg[ADDR_W-1:0];
        map_wd = {1'b0, cell_set};
        map_re = 1'b0;
        map_ra = scan_reg[ADDR_W-1:0];
        stk_we = 1'b0;
        stk_wa = top_reg[ADDR_W-1:0];
        stk_wd = nb_reg;
        stk_re = 1'b0;
        stk_ra = ADDR_W'(top_reg - CNT_W'(1));
        case (state_reg)
            ST_IDLE:
                // Loading a cell also clears its seen bit for this frame.
                map_we = accept && (load_pos_reg < area);
            ST_SCAN_RD:
                map_re = (scan_reg < area);
            ST_SCAN_CHK:
                if (scan_hit)
                begin
                    map_we = 1'b1;
                    map_wa = scan_reg[ADDR_W-1:0];
                    map_wd = 2'b11;
                    stk_we = 1'b1;
                    stk_wa = '0;
                    stk_wd = '{r: scan_r_reg, c: scan_c_reg};
                end
            ST_POP:
                stk_re = (top_reg != '0);
            ST_NB_READ:
            begin
                map_re = nb_live;
                map_ra = q_reg[ADDR_W-1:0];
            end
            ST_NB_CHK:
                if (nb_hit)
                begin
                    map_we = 1'b1;
                    map_wa = q_reg[ADDR_W-1:0];
                    map_wd = 2'b11;
                    stk_we = (top_reg < CNT_W'(CELL_TOTAL));
                end
            default: ;
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        load_pos_next = load_pos_reg;
        scan_next     = scan_reg;
        scan_r_next   = scan_r_reg;
        scan_c_next   = scan_c_reg;
        top_next      = top_reg;
        group_next    = group_reg;
        best_next     = best_reg;
        here_next     = here_reg;
        k_next        = k_reg;
        q_next        = q_reg;
        nb_ok_next    = nb_ok_reg;
        nb_next       = nb_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (load_pos_reg < area))
                    load_pos_next = load_pos_reg + CNT_W'(1);
                if (accept && frame_end)
                begin
                    scan_next   = '0;
                    scan_r_next = '0;
                    scan_c_next = '0;
                    best_next   = '0;
                    top_next    = '0;
                end
            end
            ST_SCAN_CHK:
                if (scan_hit)
                begin
                    top_next   = CNT_W'(1);
                    group_next = '0;
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                    if (CFG_W'(scan_c_reg) == cols_reg - CFG_W'(1))
                    begin
                        scan_c_next = '0;
                        scan_r_next = scan_r_reg + ROW_W'(1);
                    end
                    else
                        scan_c_next = scan_c_reg + COL_W'(1);
                end
            ST_POP:
                if (top_reg == '0)
                begin
                    // Group finished: keep the best and move the scan on.
                    if (group_reg > best_reg)
                        best_next = group_reg;
                    scan_next = scan_reg + CNT_W'(1);
                    if (CFG_W'(scan_c_reg) == cols_reg - CFG_W'(1))
                    begin
                        scan_c_next = '0;
                        scan_r_next = scan_r_reg + ROW_W'(1);
                    end
                    else
                        scan_c_next = scan_c_reg + COL_W'(1);
                end
                else
                    top_next = top_reg - CNT_W'(1);
            ST_POP_WAIT:
            begin
                here_next  = stk_rd_reg;
                group_next = group_reg + SIZE_W'(1);
                k_next     = '0;
            end
            ST_NB_CALC:
            begin
                nb_ok_next = !nr[NR_W-1] && !nc[NC_W-1]
                             && ($unsigned(nr) < NR_W'(rows_reg))
                             && ($unsigned(nc) < NC_W'(cols_reg));
                nb_next    = '{r: nr[ROW_W-1:0], c: nc[COL_W-1:0]};
                q_next     = CNT_W'(CNT_W'(nr[ROW_W-1:0]) * CNT_W'(cols_reg)
                             + CNT_W'(nc[COL_W-1:0]));
            end
            ST_NB_READ:
                if (!nb_live)
                    k_next = k_reg + 3'd1;
            ST_NB_CHK:
            begin
                if (nb_hit && (top_reg < CNT_W'(CELL_TOTAL)))
                    top_next = top_reg + CNT_W'(1);
                k_next = k_reg + 3'd1;
            end
            ST_DONE:
                load_pos_next = '0;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            load_pos_reg <= '0;
            scan_reg     <= '0;
            scan_r_reg   <= '0;
            scan_c_reg   <= '0;
            top_reg      <= '0;
            group_reg    <= '0;
            best_reg     <= '0;
            k_reg        <= '0;
            nb_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_pos_reg <= load_pos_next;
            scan_reg     <= scan_next;
            scan_r_reg   <= scan_r_next;
            scan_c_reg   <= scan_c_next;
            top_reg      <= top_next;
            group_reg    <= group_next;
            best_reg     <= best_next;
            k_reg        <= k_next;
            nb_ok_reg    <= nb_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        here_reg <= here_next;
        q_reg    <= q_next;
        nb_reg   <= nb_next;
    end

    // Cell map: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_wa] <= map_wd;
        if (map_re)
            map_rd_reg <= map_mem[map_ra];
    end

    // Search stack.
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_wa] <= stk_wd;
        if (stk_re)
            stk_rd_reg <= stk_mem[stk_ra];
    end

    assign largest_size = best_reg;

    a_top_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= CNT_W'(CELL_TOTAL))
        else $error("search stack pointer beyond stack depth");

    a_idle_stack_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (top_reg == '0))
        else $error("stack not empty while idle");

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("block did not return to idle after a result");

    a_size_in_area: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (CNT_W'(largest_size) <= area) && (CNT_W'(largest_size) <= load_pos_reg))
        else $error("largest group larger than the loaded image");

endmodule
